// ----- sv/multirange_calibration_interpolator_unit_macros.svh -----
// Assertion macros for the calibration interpolator
`ifndef MULTIRANGE_CALIBRATION_INTERPOLATOR_UNIT_MACROS_SVH
`define MULTIRANGE_CALIBRATION_INTERPOLATOR_UNIT_MACROS_SVH
// implication checked on every clock while out of reset
`define MCI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked on the next clock
`define MCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- sv/mci_pkg.sv -----
// Shared types and constants of the calibration interpolator
package mci_pkg;
    localparam int DataW = 32;
    localparam int NumRangeRegs = 4;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSEG = 2'd2;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CONV = 1'b1;
    localparam logic [2:0] REG_POINT_COUNT = 3'd0;
    localparam logic [2:0] REG_RANGE_COUNT = 3'd1;
    localparam logic [2:0] REG_FS0 = 3'd2;
    localparam logic [2:0] REG_FS1 = 3'd3;
    localparam logic [2:0] REG_FS2 = 3'd4;
    localparam logic [2:0] REG_FS3 = 3'd5;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SCAN = 9'b000000010,
        S_CHK = 9'b000000100,
        S_SRCH = 9'b000001000,
        S_MUL = 9'b000010000,
        S_DIV = 9'b000100000,
        S_RND = 9'b001000000,
        S_SAT = 9'b010000000,
        S_OUT = 9'b100000000
    } state_t;
endpackage

// ----- sv/multirange_calibration_interpolator_unit.sv -----
// Top level: calibration point table, validation, segment search and interpolation
// A load is accepted when the block is idle and its result is offered on the next
// cycle; the next input can be accepted in the cycle after that result transfers.
// A convert walks the point table in one memory, one entry per cycle. There is one
// membership pass and one pass per configured range, each closed by a check in
// S_CHK, and then a search pass. The multiply is followed by the 48-bit restoring
// divider, then rounding and saturation. An invalid count or range setting
// answers through S_OUT without any pass. A failed check answers right after the
// pass that finds it.
// There is no clearing pass: each entry carries a valid bit.
`include "multirange_calibration_interpolator_unit_macros.svh"
module multirange_calibration_interpolator_unit #(
    parameter int MAX_POINTS = 16,
    parameter int MAX_RANGES = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [3:0]            point_slot,
    input  logic signed [15:0]    raw_sample,
    input  logic [15:0]           gain_range_mv,
    input  logic [31:0]           point_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [mci_pkg::DataW-1:0] converted_value
);
    import mci_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW = $clog2(MAX_POINTS + 1);

    // configuration
    logic [7:0]  point_count_reg;
    logic [2:0]  range_count_reg;
    logic [15:0] fs_reg [NumRangeRegs];
    logic        wr_en;
    logic [2:0]  reg_idx;
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            range_count_reg <= '0;
            for (int k = 0; k < NumRangeRegs; k++) fs_reg[k] <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_POINT_COUNT: point_count_reg <= pwdata[7:0];
                REG_RANGE_COUNT: range_count_reg <= pwdata[2:0];
                REG_FS0: fs_reg[0] <= pwdata[15:0];
                REG_FS1: fs_reg[1] <= pwdata[15:0];
                REG_FS2: fs_reg[2] <= pwdata[15:0];
                REG_FS3: fs_reg[3] <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb
    begin
        case (reg_idx)
            REG_POINT_COUNT: prdata = {24'd0, point_count_reg};
            REG_RANGE_COUNT: prdata = {29'd0, range_count_reg};
            REG_FS0: prdata = {16'd0, fs_reg[0]};
            REG_FS1: prdata = {16'd0, fs_reg[1]};
            REG_FS2: prdata = {16'd0, fs_reg[2]};
            REG_FS3: prdata = {16'd0, fs_reg[3]};
            default: prdata = '0;
        endcase
    end

    // point table memory with per-entry valid bits
    logic [63:0]           mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] vld_reg;
    logic [63:0]           rd_data;
    logic                  rd_vld_reg;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         wr_addr;
    logic [63:0]           wr_data;
    always_ff @(posedge clk)
    begin
        if (mem_we) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we) vld_reg[wr_addr] <= 1'b1;
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end
    logic [63:0]        ent;
    logic [15:0]        e_gain;
    logic signed [15:0] e_code;
    logic [31:0]        e_val;
    assign ent = rd_vld_reg ? rd_data : 64'd0;
    assign e_gain = ent[15:0];
    assign e_code = ent[31:16];
    assign e_val = ent[63:32];

    // control
    state_t              state_reg, state_next;
    logic [IW-1:0]       idx_reg;      // entry being issued
    logic                rdv_reg;      // data arriving is live
    logic [3:0]          pass_reg;     // 0: membership, 1..: range pass
    logic                bad_reg;
    logic                have_prev_reg, have_pair_reg;
    logic [1:0]          n_reg;
    logic signed [15:0]  pc_reg, c0_reg, c1_reg, raw_reg;
    logic [31:0]         pv_reg, v0_reg, v1_reg;
    logic [15:0]         mv_reg;
    logic [1:0]          st_reg;
    logic [31:0]         res_reg;
    logic                ovalid_reg;
    logic signed [48:0]  num_reg;
    logic [47:0]         anum_reg, quo_reg;
    logic [47:0]         rem_reg;
    logic [16:0]         den_reg;
    logic [5:0]          dcnt_reg;
    logic                neg_reg;
    logic signed [49:0]  sres_reg;
    logic [15:0]         pass_fs;
    logic [3:0]          npass;
    logic                gain_known;
    logic [IW-1:0]       pcount;
    logic                cnt_ok;

    assign pcount = IW'(point_count_reg);
    assign cnt_ok = point_count_reg >= 8'd2 && {24'd0, point_count_reg} <= MAX_POINTS
        && range_count_reg != 3'd0 && {29'd0, range_count_reg} <= MAX_RANGES
        && range_count_reg <= 3'(NumRangeRegs);
    assign npass = {1'b0, range_count_reg} + 4'd1;
    assign pass_fs = (pass_reg >= 4'd1 && pass_reg <= 4'd4) ? fs_reg[2'(pass_reg - 4'd1)]
        : 16'd0;
    always_comb
    begin
        gain_known = 1'b0;
        for (int k = 0; k < NumRangeRegs; k++)
            if (3'(k) < range_count_reg && fs_reg[k] == e_gain) gain_known = 1'b1;
    end

    assign in_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign status = st_reg;
    assign converted_value = res_reg;
    assign mem_we = in_valid && in_ready && cmd == CMD_LOAD
        && {28'd0, point_slot} < MAX_POINTS;
    assign wr_addr = AW'(point_slot);
    assign wr_data = {point_value, raw_sample, gain_range_mv};
    assign rd_addr = AW'(idx_reg);

    logic [48:0] sub;
    assign sub = {rem_reg, anum_reg[47]} - {32'd0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
            idx_reg <= '0;
            rdv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        raw_reg <= raw_sample;
                        mv_reg <= gain_range_mv;
                        st_reg <= (cmd == CMD_CONV && !cnt_ok) ? ST_INVALID : ST_OK;
                        res_reg <= '0;
                        pass_reg <= '0;
                        bad_reg <= !cnt_ok;
                        idx_reg <= '0;
                        rdv_reg <= 1'b0;
                        have_prev_reg <= 1'b0;
                        have_pair_reg <= 1'b0;
                        n_reg <= '0;
                        if (cmd == CMD_LOAD) ovalid_reg <= 1'b1;
                    end
                end
                S_SCAN, S_SRCH:
                begin
                    rdv_reg <= idx_reg < pcount && idx_reg < IW'(MAX_POINTS);
                    if (idx_reg < pcount && idx_reg < IW'(MAX_POINTS))
                        idx_reg <= idx_reg + 1'b1;
                    if (rdv_reg)
                    begin
                        if (state_reg == S_SCAN && pass_reg == 4'd0)
                        begin
                            if (!gain_known) bad_reg <= 1'b1;
                        end
                        else if (state_reg == S_SCAN)
                        begin
                            if (e_gain == pass_fs)
                            begin
                                if (have_prev_reg && (e_code <= pc_reg || e_val <= pv_reg))
                                    bad_reg <= 1'b1;
                                pc_reg <= e_code;
                                pv_reg <= e_val;
                                have_prev_reg <= 1'b1;
                                if (n_reg != 2'd2) n_reg <= n_reg + 1'b1;
                            end
                        end
                        else if (e_gain == mv_reg && !(have_pair_reg
                            && raw_reg <= c1_reg))
                        begin
                            if (!have_prev_reg)
                            begin
                                c0_reg <= e_code;
                                v0_reg <= e_val;
                                have_prev_reg <= 1'b1;
                            end
                            else
                            begin
                                if (have_pair_reg)
                                begin
                                    c0_reg <= c1_reg;
                                    v0_reg <= v1_reg;
                                end
                                c1_reg <= e_code;
                                v1_reg <= e_val;
                                have_pair_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_CHK:
                begin
                    if (pass_reg != 4'd0 && n_reg != 2'd2) bad_reg <= 1'b1;
                    if (state_next == S_OUT) st_reg <= ST_INVALID;
                    pass_reg <= pass_reg + 1'b1;
                    idx_reg <= '0;
                    rdv_reg <= 1'b0;
                    have_prev_reg <= 1'b0;
                    n_reg <= '0;
                end
                S_MUL:
                begin
                    num_reg <= 49'((34'(signed'(raw_reg)) - 34'(signed'(c0_reg))))
                        * 49'(signed'({1'b0, v1_reg}) - signed'({1'b0, v0_reg}));
                    den_reg <= 17'(17'(signed'(c1_reg)) - 17'(signed'(c0_reg)));
                    dcnt_reg <= '0;
                    rem_reg <= '0;
                end
                S_DIV:
                begin
                    if (dcnt_reg == 6'd0)
                    begin
                        neg_reg <= num_reg[48];
                        anum_reg <= 48'(num_reg[48] ? -num_reg : num_reg);
                        dcnt_reg <= 6'd1;
                    end
                    else
                    begin
                        if (!sub[48])
                        begin
                            rem_reg <= sub[47:0];
                            quo_reg <= {quo_reg[46:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[46:0], anum_reg[47]};
                            quo_reg <= {quo_reg[46:0], 1'b0};
                        end
                        anum_reg <= {anum_reg[46:0], 1'b0};
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                end
                S_RND:
                begin
                    // magnitude rounding: rem*2 >= den rounds up
                    if ({rem_reg, 1'b0} >= {32'd0, den_reg})
                        sres_reg <= 50'(signed'({1'b0, v0_reg}))
                            + (neg_reg ? -50'(quo_reg + 48'd1) : 50'(quo_reg + 48'd1));
                    else
                        sres_reg <= 50'(signed'({1'b0, v0_reg}))
                            + (neg_reg ? -50'(quo_reg) : 50'(quo_reg));
                end
                S_SAT:
                begin
                    if (sres_reg < 0) res_reg <= '0;
                    else if (sres_reg > 50'sh0FFFFFFFF) res_reg <= '1;
                    else res_reg <= sres_reg[31:0];
                    ovalid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                end
                default: ;
            endcase
            if (state_reg == S_SCAN && state_next == S_SRCH)
            begin
                idx_reg <= '0;
                rdv_reg <= 1'b0;
                have_prev_reg <= 1'b0;
            end
            if (state_reg == S_SRCH && state_next == S_OUT) st_reg <= ST_NOSEG;
        end
    end

    logic scan_done;
    assign scan_done = !rdv_reg && !(idx_reg < pcount && idx_reg < IW'(MAX_POINTS));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready && cmd == CMD_CONV)
                    state_next = cnt_ok ? S_SCAN : S_OUT;
            S_SCAN:
                if (scan_done)
                    state_next = S_CHK;
            S_CHK:
                if (bad_reg || (pass_reg != 4'd0 && n_reg != 2'd2)) state_next = S_OUT;
                else if (pass_reg + 4'd1 == npass) state_next = S_SRCH;
                else state_next = S_SCAN;
            S_SRCH:
                if (scan_done) state_next = have_pair_reg ? S_MUL : S_OUT;
            S_MUL: state_next = S_DIV;
            S_DIV: if (dcnt_reg == 6'd48) state_next = S_RND;
            S_RND: state_next = S_SAT;
            S_SAT: state_next = S_IDLE;
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    `MCI_ASSERT_IMP(a_ready_idle, in_ready, state_reg == S_IDLE)
    `MCI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `MCI_ASSERT_IMP(a_onehot, 1'b1, $onehot(state_reg))
    `MCI_ASSERT_IMP(a_status_range, out_valid, status != 2'd3)
endmodule
